// File: rtl/heightfield_triangle_sampler_core_macros.svh
// Assertion helpers for the port checker.
`ifndef HEIGHTFIELD_TRIANGLE_SAMPLER_CORE_MACROS_SVH
`define HEIGHTFIELD_TRIANGLE_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HFTS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HFTS_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hfts_pkg.sv
package hfts_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [7:0] TILE_COUNT_RST = 8'd255;
  localparam logic [15:0] HEIGHT_SAT    = 16'hFFFF;

  // What the grid read data register holds this cycle.
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_FIRST,
    TAG_MID,
    TAG_LAST
  } rd_tag_t;

  typedef struct packed {
    rd_tag_t tag;
    logic    oor;
  } blend_ctl_t;

endpackage

// File: rtl/heightfield_triangle_sampler_core.sv
// Height field sampler. A beat with in_kind = load writes one 8-bit sample into the grid
// at (in_load_row, in_load_col) and gives no result; a load outside the grid is dropped.
// A beat with in_kind = query gives exactly one result: out_in_range = 0 and height 0
// when the integer part of x or z is not below the tile count (clamped to GRID_SIDE-1),
// else the height interpolated over the upper-left or lower-right triangle of the cell,
// in raw sample units with FRAC_BITS fraction bits. A beat is taken when start is high
// and busy is low. Loads and out-of-range queries keep busy low. An in-range query reads
// its three corners one per cycle through the single port of the grid memory, and busy
// stays high through PH_READ2 and PH_READ3 after the accept. Results show on out_valid
// for exactly one cycle and cannot be held off: an in-range result passes the grid read
// register and the accumulator into the output register; an out-of-range result passes
// oor_r into the output register. Results leave in query order while the next beat is
// already being taken. The grid has no clearing pass; a corner never loaded reads as
// garbage. Write tile_count only when the block is idle.
module heightfield_triangle_sampler_core #(
  parameter int GRID_SIDE = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [7:0]  in_load_row,
  input  logic [7:0]  in_load_col,
  input  logic [7:0]  in_sample_height,
  input  logic [15:0] in_query_x,
  input  logic [15:0] in_query_z,
  // result strobe
  output logic        out_valid,
  output logic        out_in_range,
  output logic [15:0] out_height_out,
  // tile count register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_tile_count
);
  import hfts_pkg::*;

  localparam int AW  = $clog2(GRID_SIDE);   // row / column index bits
  localparam int MAW = 2 * AW;              // grid address: {row, col}
  localparam int FW  = FRAC_BITS;
  localparam int WW  = FW + 1;              // weights run 0..ONE
  localparam logic [WW-1:0] ONE      = WW'(1) << FW;
  localparam logic [16:0]   TILE_MAX = 17'(GRID_SIDE - 1);
  localparam logic [10:0]   SIDE_11  = 11'(GRID_SIDE);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ2,
    PH_READ3
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      tile_count_r;
  rd_tag_t         rd_tag_r, issue_tag;
  logic            oor_r;

  // per-query context, held until its last corner is weighed
  logic [AW-1:0]   row_r, col_r;
  logic            tri_r;
  logic [WW-1:0]   w1_r, w2_r, w3_r;

  logic            accept;
  logic            is_query;
  logic [16:0]     tiles;
  logic [16:0]     qcx, qcz;
  logic            q_in_range;
  logic [AW-1:0]   qrow, qcol;
  logic [WW-1:0]   fx, fz, fsum;
  logic            q_tri;
  logic [WW-1:0]   w1_nxt, w2_nxt, w3_nxt;
  logic [10:0]     lrow, lcol;
  logic            load_ok;

  logic            mem_en, mem_we;
  logic [MAW-1:0]  mem_addr;
  logic [7:0]      mem_rdata;
  logic [WW-1:0]   weight;
  blend_ctl_t      bctl;

  assign busy      = (phase_r != PH_IDLE);
  assign accept    = start && !busy;
  assign is_query  = (in_kind == KIND_QUERY);
  assign cfg_ready = 1'b1;

  // --- query decode, straight off the command ports ---
  assign tiles = (17'(tile_count_r) > TILE_MAX) ? TILE_MAX : 17'(tile_count_r);
  assign qcx   = 17'(in_query_x) >> FW;
  assign qcz   = 17'(in_query_z) >> FW;
  assign q_in_range = (qcx < tiles) && (qcz < tiles);
  assign qcol  = qcx[AW-1:0];
  assign qrow  = qcz[AW-1:0];

  assign fx    = WW'(in_query_x[FW-1:0]);
  assign fz    = WW'(in_query_z[FW-1:0]);
  assign fsum  = fx + fz;
  assign q_tri = fsum[FW];   // fx + fz >= ONE: lower-right triangle

  // h1 gets fz (gz), h2 gets fx (gx), far corner the rest; ONE-fz, ONE-fx if lower-right
  assign w1_nxt = q_tri ? (ONE - fz) : fz;
  assign w2_nxt = q_tri ? (ONE - fx) : fx;
  assign w3_nxt = q_tri ? (fsum - ONE) : (ONE - fsum);

  assign lrow    = 11'(in_load_row);
  assign lcol    = 11'(in_load_col);
  assign load_ok = (lrow < SIDE_11) && (lcol < SIDE_11);

  // --- grid port schedule: h1 on accept, then h2, then h0 or h3 ---
  // Port is strictly in order, so a load always lands before any later read.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    issue_tag = TAG_NONE;
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          if (!is_query) begin
            mem_en   = load_ok;
            mem_we   = 1'b1;
            mem_addr = {lrow[AW-1:0], lcol[AW-1:0]};
          end else if (q_in_range) begin
            mem_en    = 1'b1;
            mem_addr  = {qrow + AW'(1), qcol};
            issue_tag = TAG_FIRST;
            phase_nxt = PH_READ2;
          end
        end
      end
      PH_READ2: begin
        mem_en    = 1'b1;
        mem_addr  = {row_r, col_r + AW'(1)};
        issue_tag = TAG_MID;
        phase_nxt = PH_READ3;
      end
      PH_READ3: begin
        mem_en    = 1'b1;
        mem_addr  = tri_r ? {row_r + AW'(1), col_r + AW'(1)} : {row_r, col_r};
        issue_tag = TAG_LAST;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tile_count_r <= TILE_COUNT_RST;
      rd_tag_r     <= TAG_NONE;
      oor_r        <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rd_tag_r <= issue_tag;
      // out-of-range result is registered in oor_r so it never lands on a finishing query
      oor_r    <= accept && is_query && !q_in_range;
      if (cfg_valid && cfg_ready) begin
        tile_count_r <= cfg_tile_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      row_r <= qrow;
      col_r <= qcol;
      tri_r <= q_tri;
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
      w3_r  <= w3_nxt;
    end
  end

  hfts_grid_ram #(
    .ADDR_W (MAW)
  ) u_grid (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_sample_height),
    .rdata (mem_rdata)
  );

  // weight that goes with the corner now in the read register
  always_comb begin
    case (rd_tag_r)
      TAG_FIRST: weight = w1_r;
      TAG_MID:   weight = w2_r;
      TAG_LAST:  weight = w3_r;
      default:   weight = '0;
    endcase
  end

  assign bctl = '{tag: rd_tag_r, oor: oor_r};

  hfts_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (bctl),
    .sample       (mem_rdata),
    .weight       (weight),
    .out_valid    (out_valid),
    .out_in_range (out_in_range),
    .out_height   (out_height_out)
  );

endmodule

// File: rtl/hfts_grid_ram.sv
module hfts_grid_ram #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [0:(2**ADDR_W)-1];
  logic [7:0] rdata_r;

  // single port: one read or one write per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/hfts_blend.sv
module hfts_blend #(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hfts_pkg::blend_ctl_t   ctl,
  input  logic [7:0]             sample,
  input  logic [FRAC_BITS:0]     weight,
  output logic                   out_valid,
  output logic                   out_in_range,
  output logic [15:0]            out_height
);
  import hfts_pkg::*;

  localparam int PROD_W = FRAC_BITS + 9;
  localparam int ACC_W  = (PROD_W > 17) ? PROD_W : 17;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  sum;
  logic [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  logic              out_in_range_r;
  logic [15:0]       out_height_r;

  assign prod = PROD_W'(sample) * PROD_W'(weight);
  assign sum  = acc_r + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.tag == TAG_LAST) || ctl.oor;
    end
  end

  // weighted corner sum, one corner per beat of read data
  always_ff @(posedge clk) begin
    case (ctl.tag)
      TAG_FIRST: begin
        acc_r <= ACC_W'(prod);
      end
      TAG_MID: begin
        acc_r <= sum;
      end
      TAG_LAST: begin
        out_in_range_r <= 1'b1;
        out_height_r   <= (|sum[ACC_W-1:16]) ? HEIGHT_SAT : sum[15:0];
      end
      default: begin
        if (ctl.oor) begin
          out_in_range_r <= 1'b0;
          out_height_r   <= '0;
        end
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_in_range = out_in_range_r;
  assign out_height   = out_height_r;

endmodule

// File: rtl/hfts_port_checker.sv
`include "heightfield_triangle_sampler_core_macros.svh"

module hfts_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_in_range,
  input logic [15:0] out_height_out
);

  // an out-of-range result carries zero height
  `HFTS_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && !out_in_range, out_height_out == 16'd0, "out-of-range result with nonzero height")

  // busy only comes from an accepted beat
  `HFTS_ASSERT_IMP(a_busy_cause, clk, rst_n, $rose(busy), $past(start), "busy rose without start")

  // busy, once risen, holds for PH_READ2 and PH_READ3 of an in-range query, then falls
  `HFTS_ASSERT_NXT(a_busy_len, clk, rst_n, $rose(busy), busy ##1 !busy, "busy window not two cycles")

  // last corner read is followed by an in-range result
  `HFTS_ASSERT_NXT(a_result_after, clk, rst_n, $fell(busy) && $past(rst_n), out_valid && out_in_range, "missing in-range result")

endmodule

bind heightfield_triangle_sampler_core hfts_port_checker u_port_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hfts_pkg::*;

  localparam int FRAC = 8;
  localparam int ONE  = 1 << FRAC;
  localparam int GRID = 256;

  // One expected query answer.
  typedef struct {
    logic        in_range;
    logic [15:0] height;
  } height_answer_t;

  // Mirrors the grid and tile count, predicts each query answer and
  // checks the strobed results against the oldest pending answer.
  class terrain_height_tracker;
    logic [7:0]     grid [GRID*GRID];
    logic [7:0]     tile_count;
    height_answer_t pending_heights[$];
    int             errors;

    function new();
      tile_count = TILE_COUNT_RST;
      errors     = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function height_answer_t interpolate_height(logic [15:0] qx, logic [15:0] qz);
      int tiles, cx, cz, fx, fz, h1, h2, hc, acc;
      height_answer_t ans;
      tiles = (tile_count > GRID - 1) ? GRID - 1 : tile_count;
      cx = qx >> FRAC;
      cz = qz >> FRAC;
      fx = qx & (ONE - 1);
      fz = qz & (ONE - 1);
      ans.in_range = 1'b0;
      ans.height   = '0;
      if (cx >= tiles || cz >= tiles) return ans;
      h1 = grid[(cz + 1) * GRID + cx];
      h2 = grid[cz * GRID + cx + 1];
      if (fx + fz < ONE) begin
        // upper-left triangle, weights taken from the near corner
        hc  = grid[cz * GRID + cx];
        acc = hc * (ONE - fx - fz) + h1 * fz + h2 * fx;
      end else begin
        // lower-right triangle with mirrored fractions
        hc  = grid[(cz + 1) * GRID + cx + 1];
        acc = hc * (fx + fz - ONE) + h1 * (ONE - fz) + h2 * (ONE - fx);
      end
      ans.in_range = 1'b1;
      ans.height   = (acc > HEIGHT_SAT) ? HEIGHT_SAT : acc[15:0];
      return ans;
    endfunction

    function void note_beat(logic kind, logic [7:0] row, logic [7:0] col,
                            logic [7:0] hgt, logic [15:0] qx, logic [15:0] qz);
      if (kind == KIND_LOAD) grid[row * GRID + col] = hgt;
      else pending_heights.insert(pending_heights.size(), interpolate_height(qx, qz));
    endfunction

    function void check_result(logic rng, logic [15:0] hgt);
      height_answer_t exp_ans;
      if (pending_heights.size() == 0) begin
        flag($sformatf("unexpected result: in_range=%0b height=%0d", rng, hgt));
        return;
      end
      exp_ans = pending_heights.pop_front();
      if (rng !== exp_ans.in_range || hgt !== exp_ans.height)
        flag($sformatf("height mismatch: expected in_range=%0b height=%0d, got in_range=%0b height=%0d",
                       exp_ans.in_range, exp_ans.height, rng, hgt));
    endfunction

    function int pending();
      return pending_heights.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic        in_kind          = KIND_LOAD;
  logic [7:0]  in_load_row      = '0;
  logic [7:0]  in_load_col      = '0;
  logic [7:0]  in_sample_height = '0;
  logic [15:0] in_query_x       = '0;
  logic [15:0] in_query_z       = '0;
  logic        out_valid;
  logic        out_in_range;
  logic [15:0] out_height_out;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_tile_count   = '0;

  terrain_height_tracker tracker = new();

  // Stimulus-side view: which grid points hold a sample, and which cells
  // have had all four corners loaded (reused for repeat queries).
  bit         loaded [GRID*GRID];
  logic [7:0] cur_tiles = TILE_COUNT_RST;
  int         cells_done[$];
  int         sender_idle_pct = 35;
  int         beats_sent = 0;

  heightfield_triangle_sampler_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_load_row      (in_load_row),
    .in_load_col      (in_load_col),
    .in_sample_height (in_sample_height),
    .in_query_x       (in_query_x),
    .in_query_z       (in_query_z),
    .out_valid        (out_valid),
    .out_in_range     (out_in_range),
    .out_height_out   (out_height_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tile_count   (cfg_tile_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results cannot be stalled: every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_in_range, out_height_out);
  end

  // Heights lean toward the extremes now and then.
  function automatic logic [7:0] pick_height();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Drive one beat and hold it until the edge that takes it. Called right
  // after a rising edge; start stays high into the next call unless the
  // sender decides to idle first.
  task automatic send_beat(logic kind, logic [7:0] row, logic [7:0] col,
                           logic [7:0] hgt, logic [15:0] qx, logic [15:0] qz);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start            <= 1'b1;
    in_kind          <= kind;
    in_load_row      <= row;
    in_load_col      <= col;
    in_sample_height <= hgt;
    in_query_x       <= qx;
    in_query_z       <= qz;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_beat(kind, row, col, hgt, qx, qz);
    if (kind == KIND_LOAD) loaded[row * GRID + col] = 1'b1;
    beats_sent++;
  endtask

  // Fields a load does not use still toggle.
  task automatic load_point(int row, int col, logic [7:0] hgt);
    send_beat(KIND_LOAD, 8'(row), 8'(col), hgt, 16'($urandom), 16'($urandom));
  endtask

  // In-range queries first load whichever of the three corners they read
  // has never been written.
  task automatic query_at(logic [15:0] qx, logic [15:0] qz);
    int cx, cz, fx, fz;
    cx = qx >> FRAC;
    cz = qz >> FRAC;
    fx = qx & (ONE - 1);
    fz = qz & (ONE - 1);
    if (cx < cur_tiles && cz < cur_tiles) begin
      if (!loaded[(cz + 1) * GRID + cx]) load_point(cz + 1, cx, pick_height());
      if (!loaded[cz * GRID + cx + 1]) load_point(cz, cx + 1, pick_height());
      if (fx + fz < ONE) begin
        if (!loaded[cz * GRID + cx]) load_point(cz, cx, pick_height());
      end else begin
        if (!loaded[(cz + 1) * GRID + cx + 1]) load_point(cz + 1, cx + 1, pick_height());
      end
    end
    send_beat(KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), qx, qz);
  endtask

  task automatic load_cell(int cx, int cz);
    load_point(cz, cx, pick_height());
    load_point(cz + 1, cx, pick_height());
    load_point(cz, cx + 1, pick_height());
    load_point(cz + 1, cx + 1, pick_height());
    cells_done.insert(cells_done.size(), cz * GRID + cx);
  endtask

  // Fractions hit the triangle diagonal about a quarter of the time.
  task automatic query_in_cell(int cx, int cz);
    int fx, fz;
    fx = $urandom_range(ONE - 1);
    fz = $urandom_range(ONE - 1);
    case ($urandom_range(7))
      0: fz = ONE - 1 - fx;
      1: if (fx > 0) fz = ONE - fx;
      default: ;
    endcase
    query_at(16'(cx * ONE + fx), 16'(cz * ONE + fz));
  endtask

  // Integer part at or past the tile count on one or both axes.
  task automatic query_outside();
    logic [15:0] qx, qz;
    qx = 16'($urandom);
    qz = 16'($urandom);
    case ($urandom_range(2))
      0: qx[15:8] = 8'($urandom_range(cur_tiles, 255));
      1: qz[15:8] = 8'($urandom_range(cur_tiles, 255));
      default: begin
        qx[15:8] = 8'($urandom_range(cur_tiles, 255));
        qz[15:8] = 8'($urandom_range(cur_tiles, 255));
      end
    endcase
    send_beat(KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), qx, qz);
  endtask

  // Sender holds off until every answer is back, then lets the pipe settle.
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tiles(logic [7:0] tiles);
    drain();
    cfg_valid      <= 1'b1;
    cfg_tile_count <= tiles;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid          <= 1'b0;
    tracker.tile_count  = tiles;
    cur_tiles           = tiles;
  endtask

  // Mostly well-formed cell bursts (four corner loads, then queries inside
  // the cell), plus repeat visits, uniform and out-of-range queries and
  // stray loads that may overwrite corners already in use.
  task automatic random_traffic(int n_beats);
    int goal, r, cx, cz, pick;
    goal = beats_sent + n_beats;
    while (beats_sent < goal) begin
      r = $urandom_range(99);
      if (r < 45 && cur_tiles > 0) begin
        cx = $urandom_range(cur_tiles - 1);
        cz = $urandom_range(cur_tiles - 1);
        load_cell(cx, cz);
        repeat ($urandom_range(1, 5)) query_in_cell(cx, cz);
      end else if (r < 65) begin
        query_at(16'($urandom), 16'($urandom));
      end else if (r < 75 && cells_done.size() > 0) begin
        pick = cells_done[$urandom_range(cells_done.size() - 1)];
        query_in_cell(pick % GRID, pick / GRID);
      end else if (r < 87) begin
        query_outside();
      end else begin
        load_point($urandom_range(255), $urandom_range(255), pick_height());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cell (0,0) with a flat low corner and steep neighbors,
    // probed at its corners and on both sides of the diagonal.
    load_point(0, 0, 8'd0);
    load_point(1, 0, 8'd255);
    load_point(0, 1, 8'd128);
    load_point(1, 1, 8'd255);
    query_at(16'h0000, 16'h0000);
    query_at(16'h00FF, 16'h0000);
    query_at(16'h0000, 16'h00FF);
    query_at(16'h0080, 16'h007F);
    query_at(16'h0080, 16'h0080);
    query_at(16'h00FF, 16'h00FF);
    // Last cell at full height: largest in-range position and height.
    load_cell(254, 254);
    load_point(254, 254, 8'd255);
    load_point(255, 254, 8'd255);
    load_point(254, 255, 8'd255);
    load_point(255, 255, 8'd255);
    query_at(16'hFEFF, 16'hFEFF);
    query_at(16'hFE00, 16'hFE00);
    // Just outside on x, on z, and both at the top of the range.
    query_at(16'hFF00, 16'h0000);
    query_at(16'h0000, 16'hFF00);
    query_at(16'hFFFF, 16'hFFFF);
    // Single tile: only cell (0,0) answers.
    write_tiles(8'd1);
    query_at(16'h0080, 16'h0080);
    query_at(16'h0100, 16'h0000);
    // Zero tiles: everything is outside.
    write_tiles(8'd0);
    query_at(16'h0000, 16'h0000);

    write_tiles(8'd255);
    sender_idle_pct = 35;
    random_traffic(700);

    write_tiles(8'($urandom_range(2, 254)));
    sender_idle_pct = 88;
    random_traffic(650);

    write_tiles(8'($urandom_range(1, 255)));
    sender_idle_pct = 0;
    random_traffic(650);

    drain();
    if (tracker.pending() != 0) tracker.flag("answers left over at end of run");
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hfts_pkg.sv
rtl/hfts_grid_ram.sv
rtl/hfts_blend.sv
rtl/heightfield_triangle_sampler_core.sv
rtl/hfts_port_checker.sv
bench/testbench.sv
